>>> design/maze_wall_follower_defines.svh
// Assertion macros shared by the maze wall follower RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef MAZE_WALL_FOLLOWER_DEFINES_SVH
`define MAZE_WALL_FOLLOWER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MWF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MWF_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mwf_pkg.sv
// Package for the maze wall follower: beat types, codes and the microprogram.
// Depends on nothing; used by mwf_useq and maze_wall_follower.
package mwf_pkg;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] row;
    logic [3:0] col;
    logic       open;
  } item_t;

  typedef struct packed {
    logic [3:0] pos_row;
    logic [3:0] pos_col;
    logic [1:0] heading;
    logic [1:0] cell_state;
    logic       at_exit;
    logic       no_exit;
  } result_t;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_BEGIN = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  localparam logic [1:0] HEAD_NORTH = 2'd0;
  localparam logic [1:0] HEAD_EAST  = 2'd1;
  localparam logic [1:0] HEAD_SOUTH = 2'd2;
  localparam logic [1:0] HEAD_WEST  = 2'd3;

  localparam logic [1:0] CS_WALL    = 2'd0;
  localparam logic [1:0] CS_OPEN    = 2'd1;
  localparam logic [1:0] CS_VISITED = 2'd2;

  localparam logic [1:0] TURN_AHEAD = 2'd0;
  localparam logic [1:0] TURN_RIGHT = 2'd1;
  localparam logic [1:0] TURN_BACK  = 2'd2;
  localparam logic [1:0] TURN_LEFT  = 2'd3;

  typedef logic [4:0] upc_t;

  typedef enum logic [3:0] {
    UOP_CLEAR,
    UOP_IDLE,
    UOP_LOAD_WR,
    UOP_ITEM_RD,
    UOP_ITEM_CHK,
    UOP_SCAN_INIT,
    UOP_SCAN_RD0,
    UOP_SCAN_RD1,
    UOP_SCAN_CHK,
    UOP_BEGIN_END,
    UOP_NB_RD,
    UOP_NB_TRY,
    UOP_REVERSE,
    UOP_FINISH
  } uop_e;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_JUMP,
    COND_FLAG,
    COND_DISPATCH
  } cond_e;

  typedef struct packed {
    uop_e       op;
    logic [1:0] turn;
    cond_e      cond;
    upc_t       target;
  } cw_t;

  typedef struct packed {
    logic       flag;
    logic [1:0] kind;
  } seq_in_t;

  localparam upc_t UPC_CLEAR     = 5'd0;
  localparam upc_t UPC_IDLE      = 5'd1;
  localparam upc_t UPC_LOAD      = 5'd2;
  localparam upc_t UPC_READ      = 5'd3;
  localparam upc_t UPC_READ_CHK  = 5'd4;
  localparam upc_t UPC_BEGIN     = 5'd5;
  localparam upc_t UPC_SCAN_RD0  = 5'd6;
  localparam upc_t UPC_SCAN_RD1  = 5'd7;
  localparam upc_t UPC_SCAN_CHK  = 5'd8;
  localparam upc_t UPC_BEGIN_END = 5'd9;
  localparam upc_t UPC_STEP      = 5'd10;
  localparam upc_t UPC_TRY_R     = 5'd11;
  localparam upc_t UPC_RD_A      = 5'd12;
  localparam upc_t UPC_TRY_A     = 5'd13;
  localparam upc_t UPC_RD_L      = 5'd14;
  localparam upc_t UPC_TRY_L     = 5'd15;
  localparam upc_t UPC_REVERSE   = 5'd16;
  localparam upc_t UPC_FINISH    = 5'd17;

  function automatic cw_t mk_cw(uop_e op, logic [1:0] turn, cond_e cond, upc_t target);
    cw_t w;
    w.op     = op;
    w.turn   = turn;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // The microprogram: one control word per step.
  function automatic cw_t ucode(upc_t upc);
    cw_t w;
    unique case (upc)
      UPC_CLEAR:     w = mk_cw(UOP_CLEAR,     TURN_AHEAD, COND_FLAG,     UPC_CLEAR);
      UPC_IDLE:      w = mk_cw(UOP_IDLE,      TURN_AHEAD, COND_DISPATCH, UPC_IDLE);
      UPC_LOAD:      w = mk_cw(UOP_LOAD_WR,   TURN_AHEAD, COND_JUMP,     UPC_FINISH);
      UPC_READ:      w = mk_cw(UOP_ITEM_RD,   TURN_AHEAD, COND_NEXT,     UPC_IDLE);
      UPC_READ_CHK:  w = mk_cw(UOP_ITEM_CHK,  TURN_AHEAD, COND_JUMP,     UPC_FINISH);
      UPC_BEGIN:     w = mk_cw(UOP_SCAN_INIT, TURN_AHEAD, COND_NEXT,     UPC_IDLE);
      UPC_SCAN_RD0:  w = mk_cw(UOP_SCAN_RD0,  TURN_AHEAD, COND_NEXT,     UPC_IDLE);
      UPC_SCAN_RD1:  w = mk_cw(UOP_SCAN_RD1,  TURN_AHEAD, COND_NEXT,     UPC_IDLE);
      UPC_SCAN_CHK:  w = mk_cw(UOP_SCAN_CHK,  TURN_AHEAD, COND_FLAG,     UPC_SCAN_RD0);
      UPC_BEGIN_END: w = mk_cw(UOP_BEGIN_END, TURN_AHEAD, COND_JUMP,     UPC_FINISH);
      UPC_STEP:      w = mk_cw(UOP_NB_RD,     TURN_RIGHT, COND_NEXT,     UPC_IDLE);
      UPC_TRY_R:     w = mk_cw(UOP_NB_TRY,    TURN_RIGHT, COND_FLAG,     UPC_FINISH);
      UPC_RD_A:      w = mk_cw(UOP_NB_RD,     TURN_AHEAD, COND_NEXT,     UPC_IDLE);
      UPC_TRY_A:     w = mk_cw(UOP_NB_TRY,    TURN_AHEAD, COND_FLAG,     UPC_FINISH);
      UPC_RD_L:      w = mk_cw(UOP_NB_RD,     TURN_LEFT,  COND_NEXT,     UPC_IDLE);
      UPC_TRY_L:     w = mk_cw(UOP_NB_TRY,    TURN_LEFT,  COND_FLAG,     UPC_FINISH);
      UPC_REVERSE:   w = mk_cw(UOP_REVERSE,   TURN_BACK,  COND_NEXT,     UPC_IDLE);
      UPC_FINISH:    w = mk_cw(UOP_FINISH,    TURN_AHEAD, COND_JUMP,     UPC_IDLE);
      default:       w = mk_cw(UOP_IDLE,      TURN_AHEAD, COND_JUMP,     UPC_IDLE);
    endcase
    return w;
  endfunction

  // First step of the routine for each item kind.
  function automatic upc_t entry_of(logic [1:0] kind);
    upc_t e;
    unique case (kind)
      KIND_LOAD:  e = UPC_LOAD;
      KIND_BEGIN: e = UPC_BEGIN;
      KIND_STEP:  e = UPC_STEP;
      KIND_READ:  e = UPC_READ;
      default:    e = UPC_IDLE;
    endcase
    return e;
  endfunction

endpackage

>>> design/mwf_useq.sv
// Microcode sequencer of the maze wall follower: step counter and control ROM.
// Depends on mwf_pkg for the control word, the microprogram and entry points.
module mwf_useq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mwf_pkg::seq_in_t cond_i,
  output mwf_pkg::cw_t     cw_o
);
  import mwf_pkg::*;

  upc_t upc_q, upc_d;
  cw_t  cw;

  assign cw   = ucode(upc_q);
  assign cw_o = cw;

  always_comb begin
    unique case (cw.cond)
      COND_NEXT:     upc_d = upc_q + 5'd1;
      COND_JUMP:     upc_d = cw.target;
      COND_FLAG:     upc_d = cond_i.flag ? cw.target : upc_q + 5'd1;
      COND_DISPATCH: upc_d = cond_i.flag ? entry_of(cond_i.kind) : upc_q;
      default:       upc_d = UPC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_CLEAR;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

>>> design/maze_wall_follower.sv
// Top level of the maze wall follower: datapath, cell memories and sequencer.
// Depends on mwf_pkg, mwf_useq and maze_wall_follower_defines.svh.
//
//   Channel   Ports                   Handshake
//   item      start, item_i           beat taken when start is high and busy is low
//   result    done_o, result_o        one beat per item, valid for one cycle
//
// After reset a clearing pass writes every cell with busy high. A step lasts
// longer the more neighbours are tried, and a begin the more rows it scans
// (up to GRID_SIZE rows).
// The single memory read port sets the pace; the receiver cannot stall.
// The result appears in the cycle busy falls, so the next item may start then.
`include "maze_wall_follower_defines.svh"

module maze_wall_follower #(
  parameter int GRID_SIZE = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  mwf_pkg::item_t   item_i,
  output logic             done_o,
  output mwf_pkg::result_t result_o
);
  import mwf_pkg::*;

  localparam int AW    = $clog2(GRID_SIZE);
  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int CW    = $clog2(CELLS);
  localparam logic [AW-1:0] LAST = AW'(GRID_SIZE - 1);

  function automatic logic [CW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return r * CW'(GRID_SIZE) + c;
  endfunction

  cw_t     cw;
  seq_in_t seq_in;
  logic    flag;
  logic    accept;

  // Cell memories and their ports.
  logic          open_mem [CELLS];
  logic          vis_mem  [CELLS];
  logic [CW-1:0] rd_addr, wr_addr;
  logic          wr_open_en, wr_vis_en, wr_open, wr_vis;
  logic          rd_open_q, rd_vis_q;

  // Architectural state.
  logic [AW-1:0] pos_row_q, pos_row_d, pos_col_q, pos_col_d;
  logic [1:0]    head_q, head_d;
  logic          has_exit_q, has_exit_d, exit_vis_q, exit_vis_d;
  logic [CW-1:0] exit_addr_q, exit_addr_d;
  logic [CW-1:0] clr_q, clr_d;
  logic          done_q, done_d;

  // Working registers.
  item_t         item_q, item_d;
  logic [1:0]    cs_q, cs_d;
  logic [AW-1:0] scan_q, scan_d, st_q, st_d, ex_q, ex_d;
  logic          fs_q, fs_d, fe_q, fe_d, exv_q, exv_d;
  logic [AW-1:0] nb_row_q, nb_row_d, nb_col_q, nb_col_d;
  logic [1:0]    nb_dir_q, nb_dir_d;
  logic          nb_in_q, nb_in_d;
  result_t       res_q, res_d;

  // Neighbour in the direction given by the control word's turn.
  logic [1:0]    nb_dir;
  logic          nb_in;
  logic [AW-1:0] nb_row, nb_col;
  logic          item_in, taken, hit;
  logic [CW-1:0] item_addr, nb_addr_q;

  assign accept = start && !busy;

  mwf_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (seq_in),
    .cw_o   (cw)
  );

  assign busy        = (cw.op != UOP_IDLE);
  assign seq_in.flag = flag;
  assign seq_in.kind = item_i.kind;

  assign nb_dir = head_q + cw.turn;

  always_comb begin
    nb_row = pos_row_q;
    nb_col = pos_col_q;
    unique case (nb_dir)
      HEAD_NORTH: begin
        nb_in  = (pos_row_q != '0);
        nb_row = pos_row_q - AW'(1);
      end
      HEAD_EAST: begin
        nb_in  = (pos_col_q != LAST);
        nb_col = pos_col_q + AW'(1);
      end
      HEAD_SOUTH: begin
        nb_in  = (pos_row_q != LAST);
        nb_row = pos_row_q + AW'(1);
      end
      HEAD_WEST: begin
        nb_in  = (pos_col_q != '0);
        nb_col = pos_col_q - AW'(1);
      end
      default: begin
        nb_in = 1'b0;
      end
    endcase
  end

  assign item_in   = (32'(item_q.row) < 32'(GRID_SIZE)) && (32'(item_q.col) < 32'(GRID_SIZE));
  assign item_addr = cell_addr(CW'(item_q.row), CW'(item_q.col));
  assign nb_addr_q = cell_addr(CW'(nb_row_q), CW'(nb_col_q));
  assign taken     = nb_in_q && (rd_open_q || rd_vis_q);
  assign hit       = !fe_q && rd_open_q;

  always_comb begin
    rd_addr     = item_addr;
    wr_addr     = item_addr;
    wr_open_en  = 1'b0;
    wr_vis_en   = 1'b0;
    wr_open     = 1'b0;
    wr_vis      = 1'b0;
    flag        = 1'b0;
    pos_row_d   = pos_row_q;
    pos_col_d   = pos_col_q;
    head_d      = head_q;
    has_exit_d  = has_exit_q;
    exit_vis_d  = exit_vis_q;
    exit_addr_d = exit_addr_q;
    clr_d       = clr_q;
    done_d      = 1'b0;
    item_d      = item_q;
    cs_d        = cs_q;
    scan_d      = scan_q;
    st_d        = st_q;
    ex_d        = ex_q;
    fs_d        = fs_q;
    fe_d        = fe_q;
    exv_d       = exv_q;
    nb_row_d    = nb_row_q;
    nb_col_d    = nb_col_q;
    nb_dir_d    = nb_dir_q;
    nb_in_d     = nb_in_q;
    res_d       = res_q;

    unique case (cw.op)
      UOP_CLEAR: begin
        wr_addr    = clr_q;
        wr_open_en = 1'b1;
        wr_vis_en  = 1'b1;
        clr_d      = clr_q + CW'(1);
        flag       = (clr_q != CW'(CELLS - 1));
      end
      UOP_IDLE: begin
        flag = start;
        if (start) begin
          item_d = item_i;
          cs_d   = CS_WALL;
        end
      end
      UOP_LOAD_WR: begin
        if (item_in) begin
          wr_open_en = 1'b1;
          wr_vis_en  = 1'b1;
          wr_open    = item_q.open;
        end
      end
      UOP_ITEM_RD: begin
        rd_addr = item_addr;
      end
      UOP_ITEM_CHK: begin
        if (!item_in) begin
          cs_d = CS_WALL;
        end else if (rd_vis_q) begin
          cs_d = CS_VISITED;
        end else if (rd_open_q) begin
          cs_d = CS_OPEN;
        end else begin
          cs_d = CS_WALL;
        end
      end
      UOP_SCAN_INIT: begin
        scan_d = '0;
        st_d   = '0;
        fs_d   = 1'b0;
        fe_d   = 1'b0;
      end
      UOP_SCAN_RD0: begin
        rd_addr = cell_addr(CW'(scan_q), '0);
      end
      UOP_SCAN_RD1: begin
        rd_addr = cell_addr(CW'(scan_q), CW'(LAST));
        if (!fs_q && rd_open_q) begin
          fs_d = 1'b1;
          st_d = scan_q;
        end
      end
      UOP_SCAN_CHK: begin
        if (hit) begin
          fe_d  = 1'b1;
          ex_d  = scan_q;
          exv_d = rd_vis_q;
        end
        scan_d = scan_q + AW'(1);
        flag   = (scan_q != LAST) && !(fs_q && (fe_q || hit));
      end
      UOP_BEGIN_END: begin
        has_exit_d = fe_q;
        if (fe_q) begin
          wr_addr   = cell_addr(CW'(st_q), '0);
          wr_vis_en = 1'b1;
          wr_vis    = 1'b1;
          pos_row_d = st_q;
          pos_col_d = '0;
          head_d    = HEAD_EAST;
        end
      end
      UOP_NB_RD: begin
        rd_addr  = cell_addr(CW'(nb_row), CW'(nb_col));
        nb_row_d = nb_row;
        nb_col_d = nb_col;
        nb_dir_d = nb_dir;
        nb_in_d  = nb_in;
      end
      UOP_NB_TRY: begin
        flag = taken;
        if (taken) begin
          wr_addr   = nb_addr_q;
          wr_vis_en = 1'b1;
          wr_vis    = 1'b1;
          pos_row_d = nb_row_q;
          pos_col_d = nb_col_q;
          head_d    = nb_dir_q;
        end
      end
      UOP_REVERSE: begin
        head_d = nb_dir;
        if (nb_in) begin
          pos_row_d = nb_row;
          pos_col_d = nb_col;
        end
      end
      UOP_FINISH: begin
        done_d           = 1'b1;
        res_d.pos_row    = 4'(pos_row_q);
        res_d.pos_col    = 4'(pos_col_q);
        res_d.heading    = head_q;
        res_d.cell_state = cs_q;
        res_d.at_exit    = has_exit_q && exit_vis_q;
        res_d.no_exit    = !has_exit_q;
      end
      default: begin
        flag = 1'b0;
      end
    endcase

    if (wr_vis_en && (wr_addr == exit_addr_q)) begin
      exit_vis_d = wr_vis;
    end
    if ((cw.op == UOP_BEGIN_END) && fe_q) begin
      exit_addr_d = cell_addr(CW'(ex_q), CW'(LAST));
      exit_vis_d  = exv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_open_en) begin
      open_mem[wr_addr] <= wr_open;
    end
    if (wr_vis_en) begin
      vis_mem[wr_addr] <= wr_vis;
    end
    rd_open_q <= open_mem[rd_addr];
    rd_vis_q  <= vis_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_row_q  <= '0;
      pos_col_q  <= '0;
      head_q     <= HEAD_EAST;
      has_exit_q <= 1'b0;
      exit_vis_q <= 1'b0;
      clr_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      pos_row_q  <= pos_row_d;
      pos_col_q  <= pos_col_d;
      head_q     <= head_d;
      has_exit_q <= has_exit_d;
      exit_vis_q <= exit_vis_d;
      clr_q      <= clr_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exit_addr_q <= exit_addr_d;
    item_q      <= item_d;
    cs_q        <= cs_d;
    scan_q      <= scan_d;
    st_q        <= st_d;
    ex_q        <= ex_d;
    fs_q        <= fs_d;
    fe_q        <= fe_d;
    exv_q       <= exv_d;
    nb_row_q    <= nb_row_d;
    nb_col_q    <= nb_col_d;
    nb_dir_q    <= nb_dir_d;
    nb_in_q     <= nb_in_d;
    res_q       <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  `MWF_ASSERT_NXT(a_accept_busy, accept, busy, "An accepted item did not make the block busy.")
  `MWF_ASSERT_IMP(a_done_idle, done_o, !busy, "A result beat appeared while still busy.")
  `MWF_ASSERT_IMP(a_pos_grid, 1'b1, (pos_row_q <= LAST) && (pos_col_q <= LAST),
    "The walker left the grid.")
  `MWF_ASSERT_IMP(a_exit_flags, done_o, !(result_o.at_exit && result_o.no_exit),
    "A result reports the exit both reached and missing.")

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for maze_wall_follower: a scripted maze, then random mazes and walks.
// Every beat is predicted by a wall-following model held here, or taken from the script, and checked on done_o.
// Depends on mwf_pkg and the maze_wall_follower RTL.
module tb_top;
  import mwf_pkg::*;

  localparam int GRID         = 16;
  localparam int RANDOM_BEATS = 1300;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } script_row_t;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  logic    busy;
  item_t   item_i = '0;
  logic    done_o;
  result_t result_o;

  bit         maze_open [GRID][GRID];
  bit         maze_seen [GRID][GRID];
  int         walk_row  = 0;
  int         walk_col  = 0;
  logic [1:0] facing    = HEAD_EAST;
  int         exit_line = GRID;

  result_t walk_reports [$];
  result_t oldest;
  int      mismatches  = 0;
  int      beats_sent  = 0;
  int      gap_pct     = 20;
  int      cycle_count = 0;

  script_row_t script_rows [24] = '{
    '{'{KIND_BEGIN, 4'd15, 4'd15, 1'b1}, 1'b1, '{4'd0, 4'd0, HEAD_EAST, CS_WALL, 1'b0, 1'b1}},
    '{'{KIND_STEP,  4'd0,  4'd0,  1'b0}, 1'b1, '{4'd0, 4'd0, HEAD_WEST, CS_WALL, 1'b0, 1'b1}},
    '{'{KIND_STEP,  4'd15, 4'd0,  1'b1}, 1'b1, '{4'd0, 4'd1, HEAD_EAST, CS_WALL, 1'b0, 1'b1}},
    '{'{KIND_READ,  4'd0,  4'd1,  1'b1}, 1'b1, '{4'd0, 4'd1, HEAD_EAST, CS_WALL, 1'b0, 1'b1}},
    '{'{KIND_LOAD,  4'd15, 4'd15, 1'b1}, 1'b0, '0},
    '{'{KIND_LOAD,  4'd7,  4'd15, 1'b1}, 1'b0, '0},
    '{'{KIND_BEGIN, 4'd0,  4'd15, 1'b0}, 1'b0, '0},
    '{'{KIND_READ,  4'd0,  4'd0,  1'b0}, 1'b0, '0},
    '{'{KIND_LOAD,  4'd0,  4'd0,  1'b0}, 1'b0, '0},
    '{'{KIND_READ,  4'd0,  4'd0,  1'b1}, 1'b0, '0},
    '{'{KIND_LOAD,  4'd15, 4'd0,  1'b1}, 1'b0, '0},
    '{'{KIND_LOAD,  4'd14, 4'd0,  1'b1}, 1'b0, '0},
    '{'{KIND_BEGIN, 4'd15, 4'd0,  1'b1}, 1'b0, '0},
    '{'{KIND_STEP,  4'd0,  4'd15, 1'b0}, 1'b0, '0},
    '{'{KIND_STEP,  4'd15, 4'd15, 1'b1}, 1'b0, '0},
    '{'{KIND_READ,  4'd15, 4'd15, 1'b0}, 1'b0, '0},
    '{'{KIND_READ,  4'd14, 4'd0,  1'b0}, 1'b0, '0},
    '{'{KIND_LOAD,  4'd7,  4'd15, 1'b0}, 1'b0, '0},
    '{'{KIND_BEGIN, 4'd0,  4'd0,  1'b0}, 1'b0, '0},
    '{'{KIND_STEP,  4'd0,  4'd0,  1'b1}, 1'b0, '0},
    '{'{KIND_LOAD,  4'd15, 4'd15, 1'b0}, 1'b0, '0},
    '{'{KIND_BEGIN, 4'd8,  4'd8,  1'b1}, 1'b0, '0},
    '{'{KIND_STEP,  4'd8,  4'd8,  1'b0}, 1'b0, '0},
    '{'{KIND_READ,  4'd15, 4'd0,  1'b1}, 1'b0, '0}
  };

  maze_wall_follower #(
    .GRID_SIZE(GRID)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit on_grid(int r, int c);
    return r >= 0 && r < GRID && c >= 0 && c < GRID;
  endfunction

  function automatic void neighbour(input logic [1:0] dir, output int nr, output int nc);
    nr = walk_row;
    nc = walk_col;
    case (dir)
      HEAD_NORTH: nr = nr - 1;
      HEAD_EAST:  nc = nc + 1;
      HEAD_SOUTH: nr = nr + 1;
      default:    nc = nc - 1;
    endcase
  endfunction

  function automatic result_t follow_wall(item_t it);
    logic [1:0] tries [3] = '{TURN_RIGHT, TURN_AHEAD, TURN_LEFT};
    result_t    res;
    logic [1:0] dir;
    int         nr;
    int         nc;
    int         first_open;
    int         exit_found;
    bit         moved;
    res   = '0;
    moved = 1'b0;
    case (it.kind)
      KIND_LOAD: begin
        maze_open[it.row][it.col] = it.open;
        maze_seen[it.row][it.col] = 1'b0;
      end
      KIND_BEGIN: begin
        first_open = 0;
        exit_found = GRID;
        for (int i = GRID - 1; i >= 0; i--) begin
          if (maze_open[i][0]) first_open = i;
          if (maze_open[i][GRID - 1]) exit_found = i;
        end
        exit_line = exit_found;
        if (exit_found < GRID) begin
          walk_row = first_open;
          walk_col = 0;
          facing   = HEAD_EAST;
          maze_seen[first_open][0] = 1'b1;
        end
      end
      KIND_STEP: begin
        foreach (tries[k]) begin
          if (!moved) begin
            dir = facing + tries[k];
            neighbour(dir, nr, nc);
            if (on_grid(nr, nc) && (maze_open[nr][nc] || maze_seen[nr][nc])) begin
              maze_seen[nr][nc] = 1'b1;
              walk_row = nr;
              walk_col = nc;
              facing   = dir;
              moved    = 1'b1;
            end
          end
        end
        if (!moved) begin
          facing = facing + TURN_BACK;
          neighbour(facing, nr, nc);
          if (on_grid(nr, nc)) begin
            walk_row = nr;
            walk_col = nc;
          end
        end
      end
      default: begin
        if (maze_seen[it.row][it.col]) res.cell_state = CS_VISITED;
        else if (maze_open[it.row][it.col]) res.cell_state = CS_OPEN;
        else res.cell_state = CS_WALL;
      end
    endcase
    res.pos_row = 4'(walk_row);
    res.pos_col = 4'(walk_col);
    res.heading = facing;
    res.at_exit = exit_line < GRID && maze_seen[exit_line][GRID - 1];
    res.no_exit = exit_line >= GRID;
    return res;
  endfunction

  function automatic item_t any_cell_item(logic [1:0] kind);
    item_t it;
    it.kind = kind;
    it.row  = 4'($urandom_range(15));
    it.col  = 4'($urandom_range(15));
    it.open = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic issue_item(input item_t it, input bit typed = 1'b0, input result_t want = '0);
    result_t predicted;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = follow_wall(it);
    walk_reports.push_back(typed ? want : predicted);
    beats_sent++;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (walk_reports.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        oldest = walk_reports.pop_front();
        check_field("pos_row",    oldest.pos_row,    result_o.pos_row);
        check_field("pos_col",    oldest.pos_col,    result_o.pos_col);
        check_field("heading",    oldest.heading,    result_o.heading);
        check_field("cell_state", oldest.cell_state, result_o.cell_state);
        check_field("at_exit",    oldest.at_exit,    result_o.at_exit);
        check_field("no_exit",    oldest.no_exit,    result_o.no_exit);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    item_t      it;
    logic [31:0] rnd;
    int         n;
    int         choice;
    int         line;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Every cell is written before anything can look at it.
    for (int r = 0; r < GRID; r++) begin
      for (int c = 0; c < GRID; c++) begin
        it = '{KIND_LOAD, 4'(r), 4'(c), 1'b0};
        issue_item(it);
      end
    end

    foreach (script_rows[i]) issue_item(script_rows[i].it, script_rows[i].typed,
                                        script_rows[i].want);

    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      if (beats_sent < RANDOM_BEATS / 3) gap_pct = 20;
      else if (beats_sent < 2 * RANDOM_BEATS / 3) gap_pct = 62;
      else gap_pct = 0;
      choice = $urandom_range(99);
      if (choice < 15) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          rnd = $urandom;
          it  = rnd[$bits(item_t)-1:0];
          issue_item(it);
        end
      end else begin
        if (choice < 25 || choice >= 85) begin
          line = $urandom_range(GRID - 1);
          for (int i = 0; i < GRID; i++) begin
            it = any_cell_item(KIND_LOAD);
            if (choice < 25) begin
              it.row  = 4'(i);
              it.col  = 4'(GRID - 1);
              it.open = 1'b0;
            end else begin
              it.row  = choice[0] ? 4'(i) : 4'(line);
              it.col  = choice[0] ? 4'(line) : 4'(i);
              it.open = 1'b1;
            end
            issue_item(it);
          end
        end
        n = $urandom_range(4, 20);
        repeat (n) begin
          it      = any_cell_item(KIND_LOAD);
          it.open = $urandom_range(99) < 70;
          issue_item(it);
        end
        if ($urandom_range(9) != 0) issue_item(any_cell_item(KIND_BEGIN));
        n = $urandom_range(10, 60);
        repeat (n) begin
          choice = $urandom_range(99);
          if (choice < 12) issue_item(any_cell_item(KIND_READ));
          else if (choice < 15) issue_item(any_cell_item(KIND_LOAD));
          else issue_item(any_cell_item(KIND_STEP));
        end
      end
    end

    start <= 1'b0;
    while (walk_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/mwf_pkg.sv
design/mwf_useq.sv
design/maze_wall_follower.sv
verif/tb_top.sv
